[rtl/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define PTL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define PTL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/ptl_pkg.sv]
`default_nettype none
package ptl_pkg;

	localparam int GLYPH_COUNT = 256;
	localparam int GLYPH_IDX_W = $clog2(GLYPH_COUNT);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [7:0]  CODE_SPACE   = 8'd32;
	localparam logic [7:0]  CODE_NEWLINE = 8'd10;
	localparam logic [7:0]  FIRST_CODE   = 8'd33;
	localparam logic [13:0] SRC_MAX      = 14'd16383;

	// Restoring divider: one quotient bit per step over the 8-bit glyph index.
	localparam logic [2:0] DIV_LAST = 3'd7;

	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_START = 2'd1,
		MODE_CHAR  = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CELL_W  = 3'd0,
		CFG_CELL_H  = 3'd1,
		CFG_CPR     = 3'd2,
		CFG_SPACING = 3'd3,
		CFG_DEMO    = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [6:0]        cell_width;
		logic [6:0]        cell_height;
		logic [7:0]        cells_per_row;
		logic signed [5:0] extra_spacing;
		logic              demo_style;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [7:0]         code;
		logic [7:0]         idx;
		logic [7:0]         quo;
		logic [7:0]         rem;
		logic [6:0]         glyph_width;
		logic signed [15:0] start_x;
		logic signed [15:0] start_y;
	} q_entry_t;

	typedef enum logic [1:0] {
		FE_IDLE,
		FE_DIV,
		FE_HOLD
	} front_state_t;

endpackage
`default_nettype wire

[rtl/ptl_front.sv]
`default_nettype none
module ptl_front import ptl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         mode,
	input  logic [7:0]         char_code,
	input  logic [6:0]         glyph_width,
	input  logic signed [15:0] start_x,
	input  logic signed [15:0] start_y,
	output logic               push_valid,
	input  logic               push_ready,
	output q_entry_t           push_entry
);

	front_state_t       state_q, state_nxt;
	logic [1:0]         mode_q;
	logic [7:0]         code_q;
	logic [7:0]         idx_q;
	logic [6:0]         gw_q;
	logic signed [15:0] sx_q;
	logic signed [15:0] sy_q;
	logic [7:0]         quo_q;
	logic [7:0]         rem_q;
	logic [2:0]         step_q;

	logic [7:0] cpr_eff;
	logic [8:0] trial;
	logic [8:0] diff;
	logic       ge;
	logic       accept;
	logic       is_char;

	// A zero cells-per-row acts as one.
	assign cpr_eff = (cfg.cells_per_row == 8'd0) ? 8'd1 : cfg.cells_per_row;
	assign trial   = {rem_q, quo_q[7]};
	assign ge      = trial >= {1'b0, cpr_eff};
	assign diff    = trial - {1'b0, cpr_eff};
	assign accept  = in_valid && !in_stall;
	assign is_char = (mode == MODE_CHAR);

	always_comb begin
		state_nxt  = state_q;
		in_stall   = 1'b1;
		push_valid = 1'b0;
		case (state_q)
			FE_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_nxt = is_char ? FE_DIV : FE_HOLD;
				end
			end
			FE_DIV: begin
				if (step_q == DIV_LAST) begin
					state_nxt = FE_HOLD;
				end
			end
			FE_HOLD: begin
				push_valid = 1'b1;
				if (push_ready) begin
					in_stall = 1'b0;
					if (in_valid) begin
						state_nxt = is_char ? FE_DIV : FE_HOLD;
					end else begin
						state_nxt = FE_IDLE;
					end
				end
			end
			default: state_nxt = FE_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FE_IDLE;
			step_q  <= 3'd0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				step_q <= 3'd0;
			end else if (state_q == FE_DIV) begin
				step_q <= step_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			code_q <= char_code;
			idx_q  <= char_code - FIRST_CODE;
			gw_q   <= glyph_width;
			sx_q   <= start_x;
			sy_q   <= start_y;
			quo_q  <= char_code - FIRST_CODE;
			rem_q  <= 8'd0;
		end else if (state_q == FE_DIV) begin
			quo_q <= {quo_q[6:0], ge};
			rem_q <= ge ? diff[7:0] : trial[7:0];
		end
	end

	always_comb begin
		push_entry.mode        = mode_q;
		push_entry.code        = code_q;
		push_entry.idx         = idx_q;
		push_entry.quo         = quo_q;
		push_entry.rem         = rem_q;
		push_entry.glyph_width = gw_q;
		push_entry.start_x     = sx_q;
		push_entry.start_y     = sy_q;
	end

endmodule
`default_nettype wire

[rtl/ptl_queue.sv]
`default_nettype none
module ptl_queue import ptl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  q_entry_t push_entry,
	output logic     pop_valid,
	input  logic     pop_ready,
	output q_entry_t pop_entry
);

	q_entry_t          slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              push;
	logic              pop;

	assign push_ready = (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule
`default_nettype wire

[rtl/ptl_back.sv]
`default_nettype none
module ptl_back import ptl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  q_entry_t           pop_entry,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               draw_glyph,
	output logic [13:0]        src_left,
	output logic [13:0]        src_top,
	output logic [14:0]        src_right,
	output logic [14:0]        src_bottom,
	output logic signed [15:0] dest_x,
	output logic signed [15:0] dest_y
);

	function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
		logic signed [15:0] r;
		if (v > 18'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -18'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	logic [6:0] width_mem [GLYPH_COUNT];
	logic [GLYPH_COUNT-1:0] gw_vld_q;
	logic [6:0] gw_rd_q;
	logic       gw_rd_vld_q;

	logic     valid_s1;
	q_entry_t entry_s1;
	logic     out_valid_q;

	logic signed [15:0] pen_x_q;
	logic signed [15:0] pen_y_q;
	logic signed [15:0] line_x_q;

	logic pop;
	logic adv;
	logic pop_in_range;
	logic pop_load;

	logic              is_char;
	logic              is_space;
	logic              is_nl;
	logic [14:0]       left_prod;
	logic [14:0]       top_prod;
	logic [13:0]       left;
	logic [13:0]       top;
	logic [6:0]        gw;
	logic signed [17:0] sp18;
	logic signed [17:0] cw18;
	logic signed [17:0] ch18;
	logic signed [17:0] gw18;
	logic signed [17:0] px18;
	logic signed [17:0] py18;
	logic signed [17:0] adv_space;
	logic signed [17:0] adv_nl;
	logic signed [17:0] adv_glyph;

	assign adv          = valid_s1 && (!out_valid_q || !out_stall);
	assign pop_ready    = !valid_s1 || adv;
	assign pop          = pop_valid && pop_ready;
	assign pop_load     = (pop_entry.mode == MODE_LOAD);
	assign pop_in_range = ({1'b0, pop_entry.code} < 9'(GLYPH_COUNT));

	// Width table: write on a popped load, read for every popped item.
	always_ff @(posedge clk) begin
		if (pop && pop_load && pop_in_range) begin
			width_mem[pop_entry.code[GLYPH_IDX_W-1:0]] <= pop_entry.glyph_width;
		end
		if (pop) begin
			gw_rd_q     <= width_mem[pop_entry.idx[GLYPH_IDX_W-1:0]];
			gw_rd_vld_q <= gw_vld_q[pop_entry.idx[GLYPH_IDX_W-1:0]]
				&& ({1'b0, pop_entry.idx} < 9'(GLYPH_COUNT));
			entry_s1    <= pop_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_vld_q <= '0;
		end else if (pop && pop_load && pop_in_range) begin
			gw_vld_q[pop_entry.code[GLYPH_IDX_W-1:0]] <= 1'b1;
		end
	end

	always_comb begin
		is_char   = (entry_s1.mode == MODE_CHAR);
		is_space  = (entry_s1.code == CODE_SPACE);
		is_nl     = (entry_s1.code == CODE_NEWLINE);
		left_prod = 15'(entry_s1.rem) * 15'(cfg.cell_width);
		top_prod  = 15'(entry_s1.quo) * 15'(cfg.cell_height);
		left      = (left_prod > 15'(SRC_MAX)) ? SRC_MAX : left_prod[13:0];
		top       = (top_prod > 15'(SRC_MAX)) ? SRC_MAX : top_prod[13:0];
		gw        = gw_rd_vld_q ? gw_rd_q : 7'd0;
		sp18      = {{12{cfg.extra_spacing[5]}}, cfg.extra_spacing};
		cw18      = {11'd0, cfg.cell_width};
		ch18      = {11'd0, cfg.cell_height};
		gw18      = {11'd0, gw};
		px18      = {{2{pen_x_q[15]}}, pen_x_q};
		py18      = {{2{pen_y_q[15]}}, pen_y_q};
		adv_space = cfg.demo_style ? cw18 : cw18 - 18'sd3 - (sp18 <<< 1);
		adv_nl    = ch18 + 18'sd6 + (cfg.demo_style ? 18'sd0 : sp18);
		adv_glyph = cfg.demo_style ? gw18 + 18'sd1 : gw18 - 18'sd1 + sp18;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			pen_x_q     <= '0;
			pen_y_q     <= '0;
			line_x_q    <= '0;
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (adv) begin
				case (entry_s1.mode)
					MODE_START: begin
						pen_x_q  <= entry_s1.start_x;
						line_x_q <= entry_s1.start_x;
						pen_y_q  <= entry_s1.start_y;
					end
					MODE_CHAR: begin
						if (is_space) begin
							pen_x_q <= sat16(px18 + adv_space);
						end else if (is_nl) begin
							pen_x_q <= line_x_q;
							pen_y_q <= sat16(py18 + adv_nl);
						end else begin
							pen_x_q <= sat16(px18 + adv_glyph);
						end
					end
					default: ;
				endcase
			end
		end
	end

	// Result register: non-character items report all zero.
	always_ff @(posedge clk) begin
		if (adv) begin
			draw_glyph <= is_char && !is_space && !is_nl;
			src_left   <= is_char ? left : 14'd0;
			src_top    <= is_char ? top : 14'd0;
			src_right  <= is_char ? 15'(left) + 15'(cfg.cell_width) : 15'd0;
			src_bottom <= is_char ? 15'(top) + 15'(cfg.cell_height) : 15'd0;
			dest_x     <= is_char ? pen_x_q : 16'sd0;
			dest_y     <= is_char ? pen_y_q : 16'sd0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

[rtl/proportional_text_layout_unit.sv]
`default_nettype none
// Proportional text layout unit. Feed it requests of three kinds: a load
// request writes one entry of the per-glyph width table (all entries read as
// zero after reset), a start request places the pen and the column that a
// newline returns to, and a character request yields the glyph's cell in the
// font sheet plus the pen position where it is drawn, then advances the pen
// (normal or demo spacing rules, pen saturating at 16-bit signed). Every
// request gives exactly one result; load and start results are all zero.
// The front end takes a load or start request every cycle while the queue
// accepts its entries, but takes no new request while it divides for a
// character: the sheet cell needs the glyph index divided by cells_per_row,
// done by a shared restoring divider at one quotient bit per cycle (8 steps
// plus the hand-off). A 4-entry queue sits between the front end and the
// back end, which reads the width table (one registered read port), forms
// the cell corners and moves the pen at one request per cycle while no
// result waits stalled. While a result waits, the back end holds but can
// still take one request into its first stage if that stage is empty. Write
// configuration only while the unit is idle.
module proportional_text_layout_unit import ptl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            mode,
	input  logic [7:0]            char_code,
	input  logic [6:0]            glyph_width,
	input  logic signed [15:0]    start_x,
	input  logic signed [15:0]    start_y,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  draw_glyph,
	output logic [13:0]           src_left,
	output logic [13:0]           src_top,
	output logic [14:0]           src_right,
	output logic [14:0]           src_bottom,
	output logic signed [15:0]    dest_x,
	output logic signed [15:0]    dest_y
);

	cfg_t     cfg_q;
	logic     push_valid;
	logic     push_ready;
	q_entry_t push_entry;
	logic     pop_valid;
	logic     pop_ready;
	q_entry_t pop_entry;

	// Configuration registers; an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cell_width    <= 7'd16;
			cfg_q.cell_height   <= 7'd16;
			cfg_q.cells_per_row <= 8'd16;
			cfg_q.extra_spacing <= 6'sd0;
			cfg_q.demo_style    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CELL_W:  cfg_q.cell_width    <= cfg_data[6:0];
				CFG_CELL_H:  cfg_q.cell_height   <= cfg_data[6:0];
				CFG_CPR:     cfg_q.cells_per_row <= cfg_data[7:0];
				CFG_SPACING: cfg_q.extra_spacing <= cfg_data[5:0];
				CFG_DEMO:    cfg_q.demo_style    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Front end: take the request, divide the glyph index for the sheet cell.
	ptl_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.char_code   (char_code),
		.glyph_width (glyph_width),
		.start_x     (start_x),
		.start_y     (start_y),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_entry  (push_entry)
	);

	// Decouple the divider from the pen so either side can stall alone.
	ptl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	// Back end: width table, cell corners, pen advance, result register.
	ptl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.draw_glyph (draw_glyph),
		.src_left   (src_left),
		.src_top    (src_top),
		.src_right  (src_right),
		.src_bottom (src_bottom),
		.dest_x     (dest_x),
		.dest_y     (dest_y)
	);

endmodule
`default_nettype wire

[rtl/ptl_checker.sv]
`default_nettype none
`include "assert_macros.svh"
module ptl_checker import ptl_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_we,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic [1:0]            mode,
	input logic [7:0]            char_code,
	input logic [6:0]            glyph_width,
	input logic signed [15:0]    start_x,
	input logic signed [15:0]    start_y,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic                  draw_glyph,
	input logic [13:0]           src_left,
	input logic [13:0]           src_top,
	input logic [14:0]           src_right,
	input logic [14:0]           src_bottom,
	input logic signed [15:0]    dest_x,
	input logic signed [15:0]    dest_y
);

	logic [3:0] pending_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// Requests taken but not yet answered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 4'd1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 4'd1;
		end
	end

	`PTL_ASSERT_IMP(a_no_orphan_result, out_valid, pending_q != 4'd0, "result without a request")
	`PTL_ASSERT_IMP(a_right_ge_left, out_valid, src_right >= 15'(src_left), "src_right below src_left")
	`PTL_ASSERT_IMP(a_bottom_ge_top, out_valid, src_bottom >= 15'(src_top), "src_bottom below src_top")
	`PTL_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
	`PTL_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(dest_x) && $stable(dest_y) && $stable(src_left) && $stable(draw_glyph), "stalled result changed")

	logic unused_ok;
	assign unused_ok = cfg_we ^ (^cfg_index) ^ (^cfg_data) ^ (^mode) ^ (^char_code)
		^ (^glyph_width) ^ (^start_x) ^ (^start_y) ^ (^src_top);

endmodule

bind proportional_text_layout_unit ptl_checker u_ptl_checker (.*);
`default_nettype wire

[bench/proportional_text_layout_unit_test.sv]
`timescale 1ns / 1ps

module proportional_text_layout_unit_test;
	import ptl_pkg::*;

	// Mode code with no function: the unit must leave its state alone and
	// still answer with an all-zero result.
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// Start the long receiver hold-off once this many requests have gone in.
	localparam int LONG_HOLD_AT     = 120;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int PHASE_REQUESTS   = 230;

	typedef struct packed {
		logic [1:0]         mode;
		logic [7:0]         code;
		logic [6:0]         width;
		logic signed [15:0] x;
		logic signed [15:0] y;
	} layout_req_t;

	typedef struct packed {
		logic               draw;
		logic [13:0]        left;
		logic [13:0]        top;
		logic [14:0]        right;
		logic [14:0]        bottom;
		logic signed [15:0] dest_x;
		logic signed [15:0] dest_y;
	} layout_res_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [1:0]            mode;
	logic [7:0]            char_code;
	logic [6:0]            glyph_width;
	logic signed [15:0]    start_x;
	logic signed [15:0]    start_y;
	logic                  out_valid;
	logic                  out_stall;
	logic                  draw_glyph;
	logic [13:0]           src_left;
	logic [13:0]           src_top;
	logic [14:0]           src_right;
	logic [14:0]           src_bottom;
	logic signed [15:0]    dest_x;
	logic signed [15:0]    dest_y;

	proportional_text_layout_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.char_code   (char_code),
		.glyph_width (glyph_width),
		.start_x     (start_x),
		.start_y     (start_y),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.draw_glyph  (draw_glyph),
		.src_left    (src_left),
		.src_top     (src_top),
		.src_right   (src_right),
		.src_bottom  (src_bottom),
		.dest_x      (dest_x),
		.dest_y      (dest_y)
	);

	always #6 clk = ~clk;

	// Shadow of the unit: configuration, pen and width table.
	logic [6:0]         cell_w;
	logic [6:0]         cell_h;
	logic [7:0]         cells_row;
	logic signed [5:0]  spacing;
	logic               demo;
	logic signed [15:0] pen_col;
	logic signed [15:0] pen_row;
	logic signed [15:0] line_col;
	logic [6:0]         glyph_widths [0:GLYPH_COUNT-1];

	layout_req_t req_backlog [$];   // requests not yet offered
	layout_res_t layout_expect [$]; // results predicted but not yet seen

	int offered_cnt  = 0;
	int accepted_cnt = 0;
	int result_cnt   = 0;
	int mismatches   = 0;
	bit calm         = 1'b0;        // no idling on either side when set

	// Clamp a pen coordinate to the 16-bit signed range.
	function automatic logic signed [15:0] clamp_pen(int v);
		if (v > 32767)
			return 16'sd32767;
		if (v < -32768)
			return -16'sd32768;
		return v[15:0];
	endfunction

	// Work out the result of one request and move the shadow state on.
	function automatic layout_res_t predict_layout(layout_req_t r);
		layout_res_t res;
		int idx, cpr, left, top, cw, ch, sp, gw, adv;
		res = '0;
		case (r.mode)
			MODE_LOAD: begin
				glyph_widths[r.code] = r.width;
			end
			MODE_START: begin
				pen_col  = r.x;
				line_col = r.x;
				pen_row  = r.y;
			end
			MODE_CHAR: begin
				idx  = int'(8'(r.code - FIRST_CODE));
				cpr  = (cells_row == 8'd0) ? 1 : int'(cells_row);
				cw   = int'(cell_w);
				ch   = int'(cell_h);
				sp   = int'(spacing);
				gw   = int'(glyph_widths[idx]);
				left = (idx % cpr) * cw;
				top  = (idx / cpr) * ch;
				if (left > int'(SRC_MAX))
					left = int'(SRC_MAX);
				if (top > int'(SRC_MAX))
					top = int'(SRC_MAX);
				res.draw   = (r.code != CODE_SPACE) && (r.code != CODE_NEWLINE);
				res.left   = left[13:0];
				res.top    = top[13:0];
				res.right  = 15'(left + cw);
				res.bottom = 15'(top + ch);
				res.dest_x = pen_col;
				res.dest_y = pen_row;
				if (r.code == CODE_SPACE) begin
					adv     = demo ? cw : cw - 3 - 2 * sp;
					pen_col = clamp_pen(int'(pen_col) + adv);
				end else if (r.code == CODE_NEWLINE) begin
					adv     = ch + 6 + (demo ? 0 : sp);
					pen_col = line_col;
					pen_row = clamp_pen(int'(pen_row) + adv);
				end else begin
					adv     = demo ? gw + 1 : gw - 1 + sp;
					pen_col = clamp_pen(int'(pen_col) + adv);
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// Check results as they leave, then record requests as they enter. Both
	// happen in one process so the order within the edge is fixed.
	always @(posedge clk) begin : monitor
		layout_res_t want;
		layout_req_t req;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (layout_expect.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with none pending",
						result_cnt));
				end else begin
					want = layout_expect.pop_front();
					if (draw_glyph !== want.draw)
						report_mismatch($sformatf("result %0d draw_glyph %0b, want %0b",
							result_cnt, draw_glyph, want.draw));
					if (src_left !== want.left)
						report_mismatch($sformatf("result %0d src_left %0d, want %0d",
							result_cnt, src_left, want.left));
					if (src_top !== want.top)
						report_mismatch($sformatf("result %0d src_top %0d, want %0d",
							result_cnt, src_top, want.top));
					if (src_right !== want.right)
						report_mismatch($sformatf("result %0d src_right %0d, want %0d",
							result_cnt, src_right, want.right));
					if (src_bottom !== want.bottom)
						report_mismatch($sformatf("result %0d src_bottom %0d, want %0d",
							result_cnt, src_bottom, want.bottom));
					if (dest_x !== want.dest_x)
						report_mismatch($sformatf("result %0d dest_x %0d, want %0d",
							result_cnt, dest_x, want.dest_x));
					if (dest_y !== want.dest_y)
						report_mismatch($sformatf("result %0d dest_y %0d, want %0d",
							result_cnt, dest_y, want.dest_y));
				end
				result_cnt++;
			end
			if (in_valid && !in_stall) begin
				req.mode  = mode;
				req.code  = char_code;
				req.width = glyph_width;
				req.x     = start_x;
				req.y     = start_y;
				layout_expect.push_back(predict_layout(req));
				accepted_cnt++;
			end
		end
	end

	// Request driver: hold an offered request until taken, otherwise take
	// the next one from the backlog unless a gap burst is running.
	int  src_burst_left = 0;
	bit  src_idle       = 1'b0;

	always @(negedge clk) begin : driver
		layout_req_t req;
		if (arst_n && !(in_valid && accepted_cnt != offered_cnt)) begin
			if (src_burst_left == 0) begin
				src_burst_left = $urandom_range(1, 15);
				src_idle       = !calm && ($urandom_range(0, 3) == 0);
			end
			src_burst_left--;
			if (!src_idle && req_backlog.size() != 0) begin
				req = req_backlog.pop_front();
				mode        <= req.mode;
				char_code   <= req.code;
				glyph_width <= req.width;
				start_x     <= req.x;
				start_y     <= req.y;
				in_valid    <= 1'b1;
				offered_cnt++;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver: random stall bursts, plus one long hold-off that lets
	// the unit fill up and push back on its input.
	int  snk_burst_left = 0;
	bit  snk_idle       = 1'b0;
	int  long_hold_left = 0;
	bit  long_hold_done = 1'b0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (!long_hold_done && accepted_cnt >= LONG_HOLD_AT) begin
				long_hold_left = LONG_HOLD_CYCLES;
				long_hold_done = 1'b1;
			end
			if (long_hold_left != 0) begin
				long_hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (snk_burst_left == 0) begin
					snk_burst_left = $urandom_range(1, 15);
					snk_idle       = !calm && ($urandom_range(0, 3) == 0);
				end
				snk_burst_left--;
				out_stall <= snk_idle;
			end
		end
	end

	task automatic queue_request(logic [1:0] m, logic [7:0] c, logic [6:0] w,
		logic signed [15:0] x, logic signed [15:0] y);
		layout_req_t req;
		req.mode  = m;
		req.code  = c;
		req.width = w;
		req.x     = x;
		req.y     = y;
		req_backlog.push_back(req);
	endtask

	// Pen position biased toward the saturation limits.
	function automatic logic signed [15:0] pick_position();
		case ($urandom_range(0, 3))
			0: return 16'(32767 - $urandom_range(0, 200));
			1: return 16'(-32768 + $urandom_range(0, 200));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 8'($urandom_range(33, 126));
		if (r < 75)
			return CODE_SPACE;
		if (r < 83)
			return CODE_NEWLINE;
		return 8'($urandom);
	endfunction

	// Mostly strings: a start request followed by characters; the rest is
	// width loads and loose requests of any mode, the unused one included.
	task automatic queue_random_phase(int count);
		int made, r, n;
		logic [1:0] m;
		made = 0;
		while (made < count) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				n = $urandom_range(1, 6);
				repeat (n)
					queue_request(MODE_LOAD, 8'($urandom), 7'($urandom_range(0, 64)),
						16'($urandom), 16'($urandom));
				made += n;
			end else if (r < 16) begin
				m = 2'($urandom_range(0, 3));
				queue_request(m, 8'($urandom), 7'($urandom), 16'($urandom), 16'($urandom));
				if (m != MODE_UNUSED)
					made++;
			end else begin
				queue_request(MODE_START, 8'($urandom), 7'($urandom), pick_position(),
					pick_position());
				n = $urandom_range(3, 25);
				repeat (n)
					queue_request(MODE_CHAR, pick_char(), 7'($urandom), 16'($urandom),
						16'($urandom));
				made += n + 1;
			end
		end
	endtask

	// Write one register; call at a falling edge, returns at the next one
	// with the write enable still high.
	task automatic write_reg(cfg_idx_t idx, logic [7:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			CFG_CELL_W:  cell_w    = value[6:0];
			CFG_CELL_H:  cell_h    = value[6:0];
			CFG_CPR:     cells_row = value;
			CFG_SPACING: spacing   = value[5:0];
			CFG_DEMO:    demo      = value[0];
			default: begin
			end
		endcase
		@(negedge clk);
	endtask

	task automatic apply_setting(int cw, int ch, int cpr, int sp, bit dm);
		write_reg(CFG_CELL_W, 8'(cw));
		write_reg(CFG_CELL_H, 8'(ch));
		write_reg(CFG_CPR, 8'(cpr));
		write_reg(CFG_SPACING, 8'(sp));
		write_reg(CFG_DEMO, 8'(dm));
		cfg_we <= 1'b0;
	endtask

	// Wait until every request has gone in and every result has come out.
	task automatic drain();
		while (req_backlog.size() != 0 || offered_cnt != accepted_cnt ||
			layout_expect.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = CFG_CELL_W;
		cfg_data    = '0;
		in_valid    = 1'b0;
		mode        = MODE_LOAD;
		char_code   = '0;
		glyph_width = '0;
		start_x     = '0;
		start_y     = '0;
		out_stall   = 1'b0;
		cell_w      = 7'd16;
		cell_h      = 7'd16;
		cells_row   = 8'd16;
		spacing     = '0;
		demo        = 1'b0;
		pen_col     = '0;
		pen_row     = '0;
		line_col    = '0;
		for (int i = 0; i < GLYPH_COUNT; i++)
			glyph_widths[i] = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Directed opening at reset settings: a glyph before any load, loads
		// at both ends of the table, pen saturation both ways, space and
		// newline, codes that wrap the glyph index, and the unused mode.
		queue_request(MODE_CHAR, 8'd65, 7'd0, 16'sd0, 16'sd0);
		queue_request(MODE_LOAD, 8'd0, 7'd64, 16'sd0, 16'sd0);
		queue_request(MODE_LOAD, 8'd255, 7'd64, 16'sd0, 16'sd0);
		queue_request(MODE_LOAD, 8'd32, 7'd37, 16'sd0, 16'sd0);
		queue_request(MODE_START, 8'd0, 7'd0, 16'sd32760, 16'sd32760);
		queue_request(MODE_CHAR, FIRST_CODE, 7'd0, 16'sd0, 16'sd0);
		queue_request(MODE_CHAR, 8'd65, 7'd0, 16'sd0, 16'sd0);
		queue_request(MODE_CHAR, CODE_SPACE, 7'd0, 16'sd0, 16'sd0);
		queue_request(MODE_CHAR, CODE_NEWLINE, 7'd0, 16'sd0, 16'sd0);
		queue_request(MODE_CHAR, 8'd0, 7'd0, 16'sd0, 16'sd0);
		queue_request(MODE_CHAR, 8'd255, 7'd0, 16'sd0, 16'sd0);
		queue_request(MODE_START, 8'd0, 7'd0, -16'sd32768, -16'sd32768);
		queue_request(MODE_CHAR, 8'd66, 7'd0, 16'sd0, 16'sd0);
		queue_request(MODE_CHAR, 8'd66, 7'd0, 16'sd0, 16'sd0);
		queue_request(MODE_UNUSED, 8'hFF, 7'h7F, -16'sd1, -16'sd1);
		queue_request(MODE_START, 8'd0, 7'd0, 16'sd0, 16'sd0);
		queue_request(MODE_CHAR, CODE_NEWLINE, 7'd0, 16'sd0, 16'sd0);
		queue_request(MODE_CHAR, CODE_SPACE, 7'd0, 16'sd0, 16'sd0);
		queue_random_phase(PHASE_REQUESTS);
		drain();

		// Smallest cells, single-column sheet, spacing of -16.
		apply_setting(1, 1, 1, -16, 1'b0);
		queue_random_phase(PHASE_REQUESTS);
		drain();

		// Largest cells in range, widest sheet, spacing of 16.
		apply_setting(64, 64, 255, 16, 1'b0);
		queue_random_phase(PHASE_REQUESTS);
		drain();

		// Oversized cells so the source corners clip; zero cells per row
		// behaves as one; demo rules ignore the extreme spacing.
		apply_setting(127, 127, 0, -32, 1'b1);
		queue_random_phase(PHASE_REQUESTS);
		drain();

		apply_setting($urandom_range(1, 64), $urandom_range(1, 64),
			$urandom_range(1, 255), $urandom_range(0, 32) - 16, 1'b1);
		queue_random_phase(PHASE_REQUESTS);
		drain();

		// Last stretch at full rate on both sides.
		calm = 1'b1;
		apply_setting($urandom_range(1, 64), $urandom_range(1, 64),
			$urandom_range(1, 255), 31, 1'b0);
		queue_random_phase(PHASE_REQUESTS);
		drain();

		// Give a stray late result time to show up.
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("proportional_text_layout_unit_test OK");
		else
			$display("proportional_text_layout_unit_test NOT OK");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("proportional_text_layout_unit_test NOT OK");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/ptl_pkg.sv
rtl/ptl_front.sv
rtl/ptl_queue.sv
rtl/ptl_back.sv
rtl/proportional_text_layout_unit.sv
rtl/ptl_checker.sv
bench/proportional_text_layout_unit_test.sv
